FILE: hw/rtl/arpc_pkg.sv
// Shared types and codes for the ARP cache with lifetime aging.
`default_nettype none

package arpc_pkg;

    // operation selector carried on s_tuser
    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_ADD_DEF  = 3'd1;
    localparam logic [2:0] MODE_FIND_IP  = 3'd2;
    localparam logic [2:0] MODE_FIND_ETH = 3'd3;
    localparam logic [2:0] MODE_REMOVE   = 3'd4;
    localparam logic [2:0] MODE_TICK     = 3'd5;

    // result status carried on m_tuser
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;

    localparam logic [15:0] LIFE_PERMANENT = 16'hFFFF;
    localparam logic [15:0] DEF_LIFE_RESET = 16'd60;
    localparam int          OUT_CNT_W      = 7;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] eth;
        logic [15:0] life;
    } entry_t;

    // per-slot decisions from the compare unit
    typedef struct packed {
        logic ip_hit;
        logic eth_better;
        logic free;
        logic expire;
        logic age;
        logic rank_above;
    } slot_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/arpc_slot_eval.sv
// Shared compare unit: evaluates one table slot against the current key.
`default_nettype none

module arpc_slot_eval #(
    parameter int RANK_W = 6
) (
    input  arpc_pkg::entry_t      ent,
    input  logic [RANK_W-1:0]     rank,
    input  logic [31:0]           key_ip,
    input  logic [47:0]           key_eth,
    input  logic [RANK_W-1:0]     ref_rank,
    input  logic [RANK_W-1:0]     best_rank,
    input  logic                  best_vld,
    output arpc_pkg::slot_flags_t flags,
    output logic [15:0]           life_dec
);
    import arpc_pkg::*;

    logic mortal;

    assign mortal = ent.valid && (ent.life != LIFE_PERMANENT);

    always_comb begin
        flags.ip_hit     = ent.valid && (ent.ip == key_ip);
        // earliest insertion wins among Ethernet matches
        flags.eth_better = ent.valid && (ent.eth == key_eth) &&
                           (!best_vld || (rank < best_rank));
        flags.free       = !ent.valid;
        flags.expire     = mortal && (ent.life <= 16'd1);
        flags.age        = mortal && (ent.life > 16'd1);
        flags.rank_above = ent.valid && (rank > ref_rank);
    end

    assign life_dec = ent.life - 16'd1;

endmodule

`default_nettype wire

FILE: hw/rtl/arp_cache_with_aging_unit.sv
// ARP cache top level: entry table, scan sequencer and stream ports.
`default_nettype none

// Channel    | Direction | Handshake            | Payload
// -----------+-----------+----------------------+---------------------------------------
// s_ (op)    | in        | s_tvalid / s_tready  | s_tuser mode, s_tdata ip/eth/lifetime
// m_ (result)| out       | m_tvalid / m_tready  | m_tuser status, m_tdata found/counts
// cfg_       | in        | cfg_valid / cfg_ready| cfg_data default lifetime
//
// Every add, find, remove or tick sweeps the entry table once through one read port, one
// entry per cycle; any other mode code returns not found with no sweep. A remove that hits
// adds one more sweep to close the gap in insertion order; a tick adds one such sweep per
// expired entry. After reset a clearing sweep marks every entry free before s_tready rises.
// A finished result sits in the output register; if it is not yet taken the sequencer
// waits, and the next transaction is accepted as soon as the result is loaded.

module arp_cache_with_aging_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // op transaction
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // ip_addr[31:0], eth_addr[79:32], lifetime[95:80]
    input  wire logic [2:0]   s_tuser,   // mode[2:0]
    // result transaction
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // found_ip[31:0], found_eth[79:32],
                                         // found_lifetime[95:80], entries_used[102:96],
                                         // expired_count[109:103], zero[111:110]
    output logic [2:0]        m_tuser,   // status[2:0]
    // default lifetime register write
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    import arpc_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]   CAP_CNT  = (IDX_W + 1)'(CAPACITY);

    typedef enum logic [2:0] {
        S_CLEAR,    // post-reset sweep marking all entries free
        S_IDLE,     // waiting for an op transaction
        S_SCAN,     // lookup sweep for add / find / remove
        S_RESOLVE,  // act on the sweep result
        S_TICK,     // aging sweep
        S_DEC,      // rank compaction sweep after a drop
        S_DONE      // load result register
    } state_t;

    // entry table; rank is kept alongside so its width follows CAPACITY
    entry_t           ent_mem  [CAPACITY];
    logic [IDX_W-1:0] rank_mem [CAPACITY];

    entry_t           rd_ent_reg;
    logic [IDX_W-1:0] rd_rank_reg;

    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_wrank;

    state_t           state_reg,     state_next;
    logic [IDX_W:0]   rd_idx_reg,    rd_idx_next;    // sweep read pointer
    logic             pv_reg,        pv_next;        // read data valid
    logic [IDX_W-1:0] pidx_reg,      pidx_next;      // slot of read data
    logic [CNT_W-1:0] used_reg,      used_next;
    logic [15:0]      def_life_reg,  def_life_next;
    logic             m_tvalid_reg,  m_tvalid_next;

    logic [2:0]       mode_reg,      mode_next;
    logic [31:0]      ip_reg,        ip_next;
    logic [47:0]      eth_reg,       eth_next;
    logic [15:0]      life_reg,      life_next;
    logic             hit_reg,       hit_next;
    logic             free_vld_reg,  free_vld_next;
    logic [IDX_W-1:0] free_idx_reg,  free_idx_next;
    logic [IDX_W-1:0] drop_idx_reg,  drop_idx_next;
    logic [IDX_W-1:0] ref_rank_reg,  ref_rank_next;
    logic [IDX_W-1:0] best_rank_reg, best_rank_next;
    logic [CNT_W-1:0] expired_reg,   expired_next;
    logic [2:0]       stat_reg,      stat_next;
    logic [31:0]      f_ip_reg,      f_ip_next;
    logic [47:0]      f_eth_reg,     f_eth_next;
    logic [15:0]      f_life_reg,    f_life_next;

    logic [2:0]           o_status_reg, o_status_next;
    logic [31:0]          o_ip_reg,     o_ip_next;
    logic [47:0]          o_eth_reg,    o_eth_next;
    logic [15:0]          o_life_reg,   o_life_next;
    logic [OUT_CNT_W-1:0] o_used_reg,   o_used_next;
    logic [OUT_CNT_W-1:0] o_exp_reg,    o_exp_next;

    slot_flags_t flags;
    logic [15:0] life_dec;
    logic [15:0] life_sel;
    logic        last;
    logic        issue;

    arpc_slot_eval #(
        .RANK_W (IDX_W)
    ) u_eval (
        .ent       (rd_ent_reg),
        .rank      (rd_rank_reg),
        .key_ip    (ip_reg),
        .key_eth   (eth_reg),
        .ref_rank  (ref_rank_reg),
        .best_rank (best_rank_reg),
        .best_vld  (hit_reg),
        .flags     (flags),
        .life_dec  (life_dec)
    );

    // table memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ent_mem[mem_waddr]  <= mem_wdata;
            rank_mem[mem_waddr] <= mem_wrank;
        end
        if (mem_re) begin
            rd_ent_reg  <= ent_mem[mem_raddr];
            rd_rank_reg <= rank_mem[mem_raddr];
        end
    end

    assign mem_raddr = rd_idx_reg[IDX_W-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = o_status_reg;
    assign m_tdata   = {2'b00, o_exp_reg, o_used_reg, o_life_reg, o_eth_reg, o_ip_reg};

    always_comb begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        used_next      = used_reg;
        def_life_next  = def_life_reg;
        m_tvalid_next  = m_tvalid_reg;
        mode_next      = mode_reg;
        ip_next        = ip_reg;
        eth_next       = eth_reg;
        life_next      = life_reg;
        hit_next       = hit_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        drop_idx_next  = drop_idx_reg;
        ref_rank_next  = ref_rank_reg;
        best_rank_next = best_rank_reg;
        expired_next   = expired_reg;
        stat_next      = stat_reg;
        f_ip_next      = f_ip_reg;
        f_eth_next     = f_eth_reg;
        f_life_next    = f_life_reg;
        o_status_next  = o_status_reg;
        o_ip_next      = o_ip_reg;
        o_eth_next     = o_eth_reg;
        o_life_next    = o_life_reg;
        o_used_next    = o_used_reg;
        o_exp_next     = o_exp_reg;

        mem_we    = 1'b0;
        mem_waddr = pidx_reg;
        mem_wdata = rd_ent_reg;
        mem_wrank = rd_rank_reg;
        mem_re    = 1'b0;
        life_sel  = s_tdata[95:80];

        last  = pv_reg && (pidx_reg == LAST_IDX);
        issue = 1'b0;

        if (cfg_valid) begin
            def_life_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // sweep read issue, shared by the scan, tick and compaction sweeps
        if (state_reg == S_SCAN || state_reg == S_TICK || state_reg == S_DEC) begin
            issue       = (rd_idx_reg < CAP_CNT);
            mem_re      = issue;
            pv_next     = issue;
            pidx_next   = rd_idx_reg[IDX_W-1:0];
            if (issue) begin
                rd_idx_next = rd_idx_reg + (IDX_W + 1)'(1);
            end
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we      = 1'b1;
                mem_waddr   = rd_idx_reg[IDX_W-1:0];
                mem_wdata   = '0;
                mem_wrank   = '0;
                rd_idx_next = rd_idx_reg + (IDX_W + 1)'(1);
                if (rd_idx_reg[IDX_W-1:0] == LAST_IDX) begin
                    rd_idx_next = '0;
                    state_next  = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == MODE_ADD_DEF) begin
                        life_sel = def_life_reg;
                    end
                    mode_next     = s_tuser;
                    ip_next       = s_tdata[31:0];
                    eth_next      = s_tdata[79:32];
                    // zero lifetime is stored as one
                    life_next     = (life_sel == 16'd0) ? 16'd1 : life_sel;
                    hit_next      = 1'b0;
                    free_vld_next = 1'b0;
                    expired_next  = '0;
                    stat_next     = ST_NOT_FOUND;
                    f_ip_next     = '0;
                    f_eth_next    = '0;
                    f_life_next   = '0;
                    rd_idx_next   = '0;
                    case (s_tuser)
                        MODE_ADD, MODE_ADD_DEF, MODE_FIND_IP, MODE_FIND_ETH,
                        MODE_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        MODE_TICK: begin
                            stat_next  = ST_TICK;
                            state_next = S_TICK;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (pv_reg) begin
                    if (mode_reg != MODE_FIND_ETH && flags.ip_hit) begin
                        hit_next      = 1'b1;
                        drop_idx_next = pidx_reg;
                        ref_rank_next = rd_rank_reg;
                        if (mode_reg == MODE_FIND_IP) begin
                            f_ip_next   = rd_ent_reg.ip;
                            f_eth_next  = rd_ent_reg.eth;
                            f_life_next = rd_ent_reg.life;
                        end
                    end
                    if (mode_reg == MODE_FIND_ETH && flags.eth_better) begin
                        hit_next       = 1'b1;
                        best_rank_next = rd_rank_reg;
                        f_ip_next      = rd_ent_reg.ip;
                        f_eth_next     = rd_ent_reg.eth;
                        f_life_next    = rd_ent_reg.life;
                    end
                    if (flags.free && !free_vld_reg) begin
                        free_vld_next = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                end
                if (last) begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE: begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_ADD, MODE_ADD_DEF: begin
                        // duplicate check wins over full check
                        if (hit_reg) begin
                            stat_next = ST_DUP;
                        end else if (!free_vld_reg) begin
                            stat_next = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = free_idx_reg;
                            mem_wdata.valid = 1'b1;
                            mem_wdata.ip    = ip_reg;
                            mem_wdata.eth   = eth_reg;
                            mem_wdata.life  = life_reg;
                            mem_wrank       = IDX_W'(used_reg);
                            used_next       = used_reg + CNT_W'(1);
                            stat_next       = ST_OK;
                        end
                    end
                    MODE_FIND_IP, MODE_FIND_ETH: begin
                        stat_next = hit_reg ? ST_OK : ST_NOT_FOUND;
                    end
                    MODE_REMOVE: begin
                        if (hit_reg) begin
                            mem_we       = 1'b1;
                            mem_waddr    = drop_idx_reg;
                            mem_wdata    = '0;
                            mem_wrank    = '0;
                            used_next    = used_reg - CNT_W'(1);
                            expired_next = CNT_W'(1);
                            stat_next    = ST_OK;
                            rd_idx_next  = '0;
                            state_next   = S_DEC;
                        end else begin
                            stat_next = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        stat_next = ST_NOT_FOUND;
                    end
                endcase
            end

            S_TICK: begin
                if (pv_reg) begin
                    if (flags.expire) begin
                        mem_we        = 1'b1;
                        mem_wdata     = '0;
                        mem_wrank     = '0;
                        used_next     = used_reg - CNT_W'(1);
                        expired_next  = expired_reg + CNT_W'(1);
                        ref_rank_next = rd_rank_reg;
                        drop_idx_next = pidx_reg;
                        rd_idx_next   = '0;
                        pv_next       = 1'b0;
                        state_next    = S_DEC;
                    end else begin
                        if (flags.age) begin
                            mem_we         = 1'b1;
                            mem_wdata.life = life_dec;
                        end
                        if (last) begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DEC: begin
                if (pv_reg && flags.rank_above) begin
                    mem_we    = 1'b1;
                    mem_wrank = rd_rank_reg - IDX_W'(1);
                end
                if (last) begin
                    if (mode_reg == MODE_TICK && drop_idx_reg != LAST_IDX) begin
                        // resume aging just past the dropped slot
                        rd_idx_next = {1'b0, drop_idx_reg} + (IDX_W + 1)'(1);
                        state_next  = S_TICK;
                    end else begin
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    o_status_next = stat_reg;
                    o_ip_next     = f_ip_reg;
                    o_eth_next    = f_eth_reg;
                    o_life_next   = f_life_reg;
                    o_used_next   = OUT_CNT_W'(used_reg);
                    o_exp_next    = OUT_CNT_W'(expired_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pidx_reg      <= pidx_next;
        mode_reg      <= mode_next;
        ip_reg        <= ip_next;
        eth_reg       <= eth_next;
        life_reg      <= life_next;
        hit_reg       <= hit_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        drop_idx_reg  <= drop_idx_next;
        ref_rank_reg  <= ref_rank_next;
        best_rank_reg <= best_rank_next;
        expired_reg   <= expired_next;
        stat_reg      <= stat_next;
        f_ip_reg      <= f_ip_next;
        f_eth_reg     <= f_eth_next;
        f_life_reg    <= f_life_next;
        o_status_reg  <= o_status_next;
        o_ip_reg      <= o_ip_next;
        o_eth_reg     <= o_eth_next;
        o_life_reg    <= o_life_next;
        o_used_reg    <= o_used_next;
        o_exp_reg     <= o_exp_next;
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            rd_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            used_reg     <= '0;
            def_life_reg <= DEF_LIFE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            pv_reg       <= pv_next;
            used_reg     <= used_next;
            def_life_reg <= def_life_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/arpc_port_check.sv
// Port-level checks for the ARP cache, bound to the top level.
`default_nettype none

module arpc_port_check #(
    parameter int CAPACITY = 64
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic [2:0]   m_tuser
);
    import arpc_pkg::*;

    // a held result does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one op at a time: ready drops after each accepted transaction
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second op accepted while busy");

    // found fields are only nonzero on success
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[95:0] == 96'd0))
        else $error("found fields set on a failed op");

    // only tick and a successful remove expire entries
    a_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) && (m_tuser != ST_TICK)
        |-> (m_tdata[109:103] == 7'd0))
        else $error("expired count on a non-removing op");

    // occupancy never exceeds the table size
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 127) || (m_tdata[102:96] <= 7'(CAPACITY)))
        else $error("entries_used above capacity");

endmodule

bind arp_cache_with_aging_unit arpc_port_check #(.CAPACITY(CAPACITY)) u_port_check (.*);

`default_nettype wire
